// ===== hw/rtl/tbw_pkg.sv =====
// Shared types and constants for the triangle barycentric weight block.
`default_nettype none
package tbw_pkg;
  localparam int COORD_BITS  = 12;
  localparam int FRAC_BITS   = 16;
  localparam int WEIGHT_BITS = 20;
  localparam int DIFF_BITS   = COORD_BITS + 1;
  localparam int PROD_BITS   = 2 * DIFF_BITS;
  localparam int CROSS_BITS  = PROD_BITS + 1;
  localparam int NUM_BITS    = CROSS_BITS + 2;
  localparam int DIV_BITS    = NUM_BITS + FRAC_BITS;
  localparam int DEN_BITS    = CROSS_BITS;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam logic signed [WEIGHT_BITS-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
  localparam logic signed [WEIGHT_BITS-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
  localparam logic signed [WEIGHT_BITS-1:0] WEIGHT_NEG_ONE =
    (FRAC_BITS >= WEIGHT_BITS - 1) ? WEIGHT_MIN
      : WEIGHT_BITS'(-(64'sd1 <<< FRAC_BITS));

  typedef struct packed {
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic [COORD_BITS-1:0] vert_a_x;
    logic [COORD_BITS-1:0] vert_a_y;
    logic [COORD_BITS-1:0] vert_b_x;
    logic [COORD_BITS-1:0] vert_b_y;
    logic [COORD_BITS-1:0] vert_c_x;
    logic [COORD_BITS-1:0] vert_c_y;
  } tbw_in_t;

  typedef struct packed {
    logic signed [WEIGHT_BITS-1:0] weight_a;
    logic signed [WEIGHT_BITS-1:0] weight_b;
    logic signed [WEIGHT_BITS-1:0] weight_c;
    logic                          degenerate;
  } tbw_out_t;

  // Work handed from the front to the back end.
  typedef struct packed {
    logic signed [CROSS_BITS-1:0] tx;
    logic signed [CROSS_BITS-1:0] ty;
    logic signed [CROSS_BITS-1:0] tz;
  } tbw_job_t;
endpackage
`default_nettype wire

// ===== hw/rtl/tbw_front.sv =====
// Front end: edge vectors and cross products, two pipeline stages.
`default_nettype none
module tbw_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  tbw_pkg::tbw_in_t     in_data,
  output logic                 job_valid,
  input  wire                  job_ready,
  output tbw_pkg::tbw_job_t    job
);
  import tbw_pkg::*;

  logic s1_valid_r;
  logic signed [PROD_BITS-1:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic s2_valid_r;
  tbw_job_t job_r;
  logic signed [DIFF_BITS-1:0] abx, aby, acx, acy, pax, pay;
  logic s1_adv, s2_adv;

  assign s2_adv   = !s2_valid_r || job_ready;
  assign s1_adv   = !s1_valid_r || s2_adv;
  assign in_ready = s1_adv;

  always_comb begin
    abx = $signed({1'b0, in_data.vert_b_x}) - $signed({1'b0, in_data.vert_a_x});
    aby = $signed({1'b0, in_data.vert_b_y}) - $signed({1'b0, in_data.vert_a_y});
    acx = $signed({1'b0, in_data.vert_c_x}) - $signed({1'b0, in_data.vert_a_x});
    acy = $signed({1'b0, in_data.vert_c_y}) - $signed({1'b0, in_data.vert_a_y});
    pax = $signed({1'b0, in_data.vert_a_x}) - $signed({1'b0, in_data.point_x});
    pay = $signed({1'b0, in_data.vert_a_y}) - $signed({1'b0, in_data.point_y});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_adv) s1_valid_r <= in_valid;
      if (s2_adv) s2_valid_r <= s1_valid_r;
    end
    if (s1_adv && in_valid) begin
      p0_r <= abx * pay;
      p1_r <= pax * aby;
      p2_r <= pax * acy;
      p3_r <= acx * pay;
      p4_r <= acx * aby;
      p5_r <= abx * acy;
    end
    if (s2_adv && s1_valid_r) begin
      job_r.tx <= CROSS_BITS'(p0_r) - CROSS_BITS'(p1_r);
      job_r.ty <= CROSS_BITS'(p2_r) - CROSS_BITS'(p3_r);
      job_r.tz <= CROSS_BITS'(p4_r) - CROSS_BITS'(p5_r);
    end
  end

  assign job_valid = s2_valid_r;
  assign job       = job_r;
endmodule
`default_nettype wire

// ===== hw/rtl/tbw_queue.sv =====
// Short FIFO between the front and back ends.
`default_nettype none
module tbw_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 wr_valid,
  output logic                wr_ready,
  input  tbw_pkg::tbw_job_t   wr_data,
  output logic                rd_valid,
  input  wire                 rd_ready,
  output tbw_pkg::tbw_job_t   rd_data
);
  import tbw_pkg::*;

  tbw_job_t mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wp_r, rp_r;
  logic [QPTR_BITS:0]   cnt_r;
  logic wr, rd;

  assign wr_ready = cnt_r != (QPTR_BITS+1)'(QUEUE_DEPTH);
  assign rd_valid = cnt_r != '0;
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QPTR_BITS+1)'(wr) - (QPTR_BITS+1)'(rd);
    end
    if (wr) mem_r[wp_r] <= wr_data;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/tbw_div.sv =====
// Pipelined signed divider: one quotient bit per stage, truncating, saturated.
`default_nettype none
module tbw_div (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  adv,
  input  wire                                  in_valid,
  input  wire  signed [tbw_pkg::NUM_BITS-1:0]  num,
  input  wire  signed [tbw_pkg::DEN_BITS-1:0]  den,
  output logic                                 out_valid,
  output logic signed [tbw_pkg::WEIGHT_BITS-1:0] quo
);
  import tbw_pkg::*;

  localparam int STAGES = DIV_BITS;

  logic [STAGES:0]             v_r;
  logic [DIV_BITS-1:0]         q_r   [STAGES+1];
  logic [DEN_BITS:0]           rem_r [STAGES+1];
  logic [DEN_BITS-1:0]         d_r   [STAGES+1];
  logic                        neg_r [STAGES+1];
  logic [NUM_BITS-1:0]         nmag;
  logic [DEN_BITS-1:0]         dmag;
  logic [DIV_BITS-1:0]         mag;
  logic signed [DIV_BITS+1:0]  sq;

  assign nmag = num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);
  assign dmag = den[DEN_BITS-1] ? DEN_BITS'(-den) : DEN_BITS'(den);

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[STAGES-1:0], in_valid};
    if (adv) begin
      q_r[0]   <= {nmag, {FRAC_BITS{1'b0}}};
      rem_r[0] <= '0;
      d_r[0]   <= dmag;
      neg_r[0] <= num[NUM_BITS-1] ^ den[DEN_BITS-1];
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic [DEN_BITS:0]  sh;
    logic [DEN_BITS+1:0] diff;
    assign sh   = {rem_r[i][DEN_BITS-1:0], q_r[i][DIV_BITS-1]};
    assign diff = {1'b0, sh} - {2'b0, d_r[i]};
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!diff[DEN_BITS+1]) begin
          rem_r[i+1] <= diff[DEN_BITS:0];
          q_r[i+1]   <= {q_r[i][DIV_BITS-2:0], 1'b1};
        end else begin
          rem_r[i+1] <= sh;
          q_r[i+1]   <= {q_r[i][DIV_BITS-2:0], 1'b0};
        end
        d_r[i+1]   <= d_r[i];
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  assign mag = q_r[STAGES];
  assign sq  = neg_r[STAGES] ? -$signed({2'b0, mag}) : $signed({2'b0, mag});

  always_comb begin
    if (sq > $signed((DIV_BITS+2)'(WEIGHT_MAX))) quo = WEIGHT_MAX;
    else if (sq < (DIV_BITS+2)'(WEIGHT_MIN)) quo = WEIGHT_MIN;
    else quo = WEIGHT_BITS'(sq);
  end
  assign out_valid = v_r[STAGES];
endmodule
`default_nettype wire

// ===== hw/rtl/tbw_back.sv =====
// Back end: numerators and three pipelined dividers, stalled as one pipe.
`default_nettype none
module tbw_back (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                job_valid,
  output logic               job_ready,
  input  tbw_pkg::tbw_job_t  job,
  output logic               out_valid,
  input  wire                out_ready,
  output tbw_pkg::tbw_out_t  out_data
);
  import tbw_pkg::*;

  localparam int LAT = DIV_BITS + 1;

  logic adv;
  logic signed [NUM_BITS-1:0] na;
  logic signed [DEN_BITS-1:0] den;
  logic [LAT-1:0] degen_r;
  logic va, vb, vc;
  logic signed [WEIGHT_BITS-1:0] qa, qb, qc;
  logic zero;

  // Stall the whole divider pipe while the output holds a beat.
  assign adv = !out_valid || out_ready;
  assign job_ready = adv;
  assign zero = job.tz == '0;
  // Degenerate beats divide by one to keep the divider well defined.
  assign den = zero ? DEN_BITS'(1) : job.tz;
  assign na  = NUM_BITS'(job.tz) - NUM_BITS'(job.tx) - NUM_BITS'(job.ty);

  tbw_div u_div_a (.clk, .rst_n, .adv, .in_valid(job_valid), .num(na), .den,
                   .out_valid(va), .quo(qa));
  tbw_div u_div_b (.clk, .rst_n, .adv, .in_valid(job_valid),
                   .num(NUM_BITS'(job.ty)), .den, .out_valid(vb), .quo(qb));
  tbw_div u_div_c (.clk, .rst_n, .adv, .in_valid(job_valid),
                   .num(NUM_BITS'(job.tx)), .den, .out_valid(vc), .quo(qc));

  always_ff @(posedge clk) begin
    if (adv) degen_r <= {degen_r[LAT-2:0], zero};
  end

  always_comb begin
    out_valid = va && vb && vc;
    out_data.degenerate = degen_r[LAT-1];
    out_data.weight_a = degen_r[LAT-1] ? WEIGHT_NEG_ONE : qa;
    out_data.weight_b = degen_r[LAT-1] ? WEIGHT_NEG_ONE : qb;
    out_data.weight_c = degen_r[LAT-1] ? WEIGHT_NEG_ONE : qc;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/triangle_barycentric_weights.sv =====
// Top level of the triangle barycentric weight block.
`default_nettype none
// Fully pipelined: one beat per cycle in and out while out_ready is high. The
// path is 2 front stages, the queue, and DIV_BITS+1 (46 by default) divider
// stages, set by the restoring divider that retires one quotient bit per stage.
// The queue lets the front keep taking beats while the back end is stalled, until full.
module triangle_barycentric_weights (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  tbw_pkg::tbw_in_t   in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output tbw_pkg::tbw_out_t  out_data
);
  import tbw_pkg::*;

  logic     f_valid, f_ready, q_valid, q_ready;
  tbw_job_t f_job, q_job;

  tbw_front u_front (.clk, .rst_n, .in_valid, .in_ready, .in_data,
                     .job_valid(f_valid), .job_ready(f_ready), .job(f_job));
  tbw_queue u_queue (.clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready),
                     .wr_data(f_job), .rd_valid(q_valid), .rd_ready(q_ready),
                     .rd_data(q_job));
  tbw_back  u_back  (.clk, .rst_n, .job_valid(q_valid), .job_ready(q_ready),
                     .job(q_job), .out_valid, .out_ready, .out_data);

  a_degen_weights: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |-> out_data.weight_a == WEIGHT_NEG_ONE &&
      out_data.weight_b == WEIGHT_NEG_ONE && out_data.weight_c == WEIGHT_NEG_ONE)
    else $error("degenerate beat with wrong weights");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
  a_queue_flow: assert property (@(posedge clk) disable iff (!rst_n)
    f_valid && !f_ready |=> f_valid)
    else $error("front dropped a beat");
endmodule
`default_nettype wire

// ===== tb/tbw_checker.sv =====
// Checker for the triangle barycentric weight block: predicts and compares result beats.
`timescale 1ns / 100ps
`default_nettype none
module tbw_checker (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  input  wire               in_ready,
  input  tbw_pkg::tbw_in_t  in_data,
  input  wire               out_valid,
  input  wire               out_ready,
  input  tbw_pkg::tbw_out_t out_data,
  output int                fail_count,
  output int                pending
);
  import tbw_pkg::*;

  tbw_out_t weights_due[$];

  function automatic logic signed [WEIGHT_BITS-1:0] clamp_weight(longint w);
    if (w > longint'(WEIGHT_MAX)) return WEIGHT_MAX;
    if (w < longint'(WEIGHT_MIN)) return WEIGHT_MIN;
    return WEIGHT_BITS'(w);
  endfunction

  // Truncating division of the scaled numerator; SV '/' rounds toward zero.
  function automatic logic signed [WEIGHT_BITS-1:0] fixed_ratio(longint num, longint den);
    longint scaled;
    scaled = num * (longint'(1) <<< FRAC_BITS);
    return clamp_weight(scaled / den);
  endfunction

  function automatic tbw_out_t barycentric_weights(tbw_in_t t);
    longint px, py, ax, ay, bx, by, cx, cy;
    longint abx, aby, acx, acy, pax, pay, tx, ty, tz;
    tbw_out_t r;
    px = t.point_x;  py = t.point_y;
    ax = t.vert_a_x; ay = t.vert_a_y;
    bx = t.vert_b_x; by = t.vert_b_y;
    cx = t.vert_c_x; cy = t.vert_c_y;
    abx = bx - ax; aby = by - ay;
    acx = cx - ax; acy = cy - ay;
    pax = ax - px; pay = ay - py;
    tx = abx * pay - pax * aby;
    ty = pax * acy - acx * pay;
    tz = acx * aby - abx * acy;
    if (tz == 0) begin
      r.weight_a = clamp_weight(-(longint'(1) <<< FRAC_BITS));
      r.weight_b = r.weight_a;
      r.weight_c = r.weight_a;
      r.degenerate = 1'b1;
    end else begin
      r.weight_a = fixed_ratio(tz - tx - ty, tz);
      r.weight_b = fixed_ratio(ty, tz);
      r.weight_c = fixed_ratio(tx, tz);
      r.degenerate = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending = weights_due.size();

  always @(posedge clk) begin
    tbw_out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) weights_due.push_back(barycentric_weights(in_data));
      if (out_valid && out_ready) begin
        if (weights_due.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = weights_due.pop_front();
          if (out_data.weight_a !== want.weight_a)
            report_mismatch($sformatf("weight_a %0d want %0d", out_data.weight_a, want.weight_a));
          if (out_data.weight_b !== want.weight_b)
            report_mismatch($sformatf("weight_b %0d want %0d", out_data.weight_b, want.weight_b));
          if (out_data.weight_c !== want.weight_c)
            report_mismatch($sformatf("weight_c %0d want %0d", out_data.weight_c, want.weight_c));
          if (out_data.degenerate !== want.degenerate)
            report_mismatch($sformatf("degenerate %0b want %0b", out_data.degenerate,
                                      want.degenerate));
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== tb/tb_triangle_barycentric_weights.sv =====
// Testbench top for the triangle barycentric weight block: stimulus and verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb_triangle_barycentric_weights;
  import tbw_pkg::*;

  localparam int SETTLE_CYCLES = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  tbw_in_t in_data = '0;
  logic in_ready, out_valid;
  tbw_out_t out_data;
  int fail_count, pending;
  int send_idle_pct, recv_stall_pct;

  triangle_barycentric_weights dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  tbw_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return COORD_BITS'($urandom_range(7));
      3: return COORD_BITS'(4095 - $urandom_range(7));
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  // Random triangles, small ones with the point near them, corner coordinates, some degenerate shapes.
  function automatic tbw_in_t rand_triangle();
    tbw_in_t t;
    int kind;
    t = tbw_in_t'({$urandom, $urandom, $urandom});
    kind = $urandom_range(9);
    if (kind == 0) begin
      t.vert_b_x = t.vert_a_x; t.vert_b_y = t.vert_a_y;
    end else if (kind == 1) begin
      t.vert_a_x = COORD_BITS'(100); t.vert_a_y = COORD_BITS'(100);
      t.vert_b_x = COORD_BITS'(100 + $urandom_range(50)); t.vert_b_y = t.vert_b_x;
      t.vert_c_x = COORD_BITS'(100 + $urandom_range(50)); t.vert_c_y = t.vert_c_x;
    end else if (kind == 2) begin
      t.point_x = rand_coord(); t.point_y = rand_coord();
      t.vert_a_x = rand_coord(); t.vert_a_y = rand_coord();
      t.vert_b_x = rand_coord(); t.vert_b_y = rand_coord();
      t.vert_c_x = rand_coord(); t.vert_c_y = rand_coord();
    end else if (kind <= 5) begin
      // small triangle: tiny area drives weights into saturation
      t.vert_b_x = COORD_BITS'(t.vert_a_x + $urandom_range(3));
      t.vert_b_y = COORD_BITS'(t.vert_a_y + $urandom_range(3));
      t.vert_c_x = COORD_BITS'(t.vert_a_x - $urandom_range(3));
      t.vert_c_y = COORD_BITS'(t.vert_a_y + $urandom_range(3));
      t.point_x = COORD_BITS'(t.vert_a_x + $urandom_range(8) - 4);
      t.point_y = COORD_BITS'(t.vert_a_y + $urandom_range(8) - 4);
    end
    return t;
  endfunction

  // Valid stays high into the next beat when the sender does not idle.
  task automatic send_triangle(tbw_in_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_directed(int px, int py, int ax, int ay, int bx, int by,
                               int cx, int cy);
    tbw_in_t t;
    t.point_x = COORD_BITS'(px); t.point_y = COORD_BITS'(py);
    t.vert_a_x = COORD_BITS'(ax); t.vert_a_y = COORD_BITS'(ay);
    t.vert_b_x = COORD_BITS'(bx); t.vert_b_y = COORD_BITS'(by);
    t.vert_c_x = COORD_BITS'(cx); t.vert_c_y = COORD_BITS'(cy);
    send_triangle(t);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_directed(0, 0, 0, 0, 0, 0, 0, 0);
    send_directed(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095);
    send_directed(0, 0, 0, 0, 4095, 0, 0, 4095);
    send_directed(4095, 4095, 0, 0, 4095, 0, 0, 4095);
    send_directed(0, 4095, 0, 0, 0, 4095, 4095, 0);
    send_directed(10, 10, 0, 0, 20, 0, 0, 20);
    send_directed(0, 0, 4095, 4095, 0, 4095, 4095, 0);
    send_directed(4095, 0, 0, 0, 1, 0, 0, 1);
    send_directed(0, 4095, 4095, 0, 4094, 0, 4095, 1);
    send_directed(5, 5, 1, 1, 2, 2, 3, 3);
    send_directed(100, 100, 10, 20, 10, 20, 300, 400);
    send_directed(1, 1, 0, 0, 1, 0, 0, 1);
    send_directed(2048, 2048, 0, 0, 4095, 4095, 4095, 0);
    send_directed(3000, 17, 4000, 4000, 0, 0, 4095, 1);
    // hold off until the pipe is empty
    drain_results();
    send_directed(1, 2, 0, 0, 2, 1, 1, 2);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      for (int i = 0; i < 285; i++) send_triangle(rand_triangle());
    end
    recv_stall_pct = 0;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb_triangle_barycentric_weights: clean");
    else
      $display("tb_triangle_barycentric_weights: errors");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_triangle_barycentric_weights: errors");
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
hw/rtl/tbw_pkg.sv
hw/rtl/tbw_front.sv
hw/rtl/tbw_queue.sv
hw/rtl/tbw_div.sv
hw/rtl/tbw_back.sv
hw/rtl/triangle_barycentric_weights.sv
tb/tbw_checker.sv
tb/tb_triangle_barycentric_weights.sv
